>>> design/modbus_rtu_response_checker_macros.svh
// Assertion macros shared by the checker RTL.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define MRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/mrc_pkg.sv
package mrc_pkg;

  localparam int FRAME_MAX_DEF = 64;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] ADDR_RESET = 8'd1;
  localparam logic [6:0] FUNC_RESET = 7'd3;
  localparam logic [5:0] DLEN_RESET = 6'd0;

  // Configuration register indexes.
  localparam logic [1:0] REG_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_FUNCTION = 2'd1;
  localparam logic [1:0] REG_DATA_LEN = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CRC_BAD  = 3'd1;
  localparam logic [2:0] ST_ADDR_BAD = 3'd2;
  localparam logic [2:0] ST_FUNC_BAD = 3'd3;
  localparam logic [2:0] ST_EXCEPT   = 3'd4;
  localparam logic [2:0] ST_LEN_BAD  = 3'd5;
  localparam logic [2:0] ST_SIZE_BAD = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_req_t;

  typedef struct packed {
    logic       is_status;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [7:0] payload_byte;
    logic       last;
  } rsp_item_t;

endpackage

>>> design/modbus_rtu_response_checker.sv
// The third and later bytes of a frame are accepted, then run 8 bit-serial CRC steps in S_CRC;
// the first two bytes and dropped overflow bytes take only the accept. The status item is on
// the ports in the cycle after the final byte's CRC steps, or in the cycle right after its
// accept when none run; each payload byte then passes through S_RD (frame store read) and
// S_EMIT (emit), with busy high throughout; a request is not taken while busy. Reset (rst,
// synchronous, active high) clears frame state and loads register defaults, not the frame store.
`include "modbus_rtu_response_checker_macros.svh"

module modbus_rtu_response_checker #(
  parameter int FRAME_MAX = mrc_pkg::FRAME_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Request channel: one frame byte per request.
  input  logic              start,
  output logic              busy,
  input  mrc_pkg::rx_req_t  request,
  // Result channel: one item per strobe, never stalled.
  output logic              result_valid,
  output mrc_pkg::rsp_item_t result,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import mrc_pkg::*;

  // Byte count must hold FRAME_MAX itself; the store index only needs its depth.
  localparam int CW = $clog2(FRAME_MAX + 1);
  localparam int AW = $clog2(FRAME_MAX);
  // Width used for the payload length compare against the 6-bit register.
  localparam int LW = (CW > 6) ? CW : 6;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CRC   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]    state;

  // Configuration registers.
  logic [7:0]    exp_addr;
  logic [6:0]    exp_func;
  logic [5:0]    exp_dlen;

  // Frame state.
  logic [CW-1:0] byte_count;
  logic [15:0]   running_crc;
  logic          size_overflow;
  logic          end_seen;

  // The two most recent stored bytes: they are the CRC field once the frame ends,
  // and the older one is the next byte to fold into the CRC.
  logic [7:0]    hold_new;
  logic [7:0]    hold_old;

  // Header bytes captured as they arrive so the check needs no store reads.
  logic [7:0]    hdr_addr;
  logic [7:0]    hdr_func;
  logic [7:0]    hdr_b2;

  // Bit-serial CRC datapath.
  logic [7:0]    crc_shift;
  logic [2:0]    bit_cnt;

  // Frame store and payload readout.
  logic [7:0]    frame_store [FRAME_MAX];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] last_addr;

  logic          accepted;
  logic          has_room;
  logic          crc_fb;
  logic [2:0]    chk_status;
  logic [LW-1:0] pay_len;

  assign busy      = (state != S_IDLE);
  assign accepted  = start && !busy;
  assign has_room  = (byte_count < CW'(FRAME_MAX));
  assign cfg_ready = 1'b1;

  assign crc_fb  = running_crc[0] ^ crc_shift[0];
  assign pay_len = LW'(byte_count) - LW'(4);

  // Frame checks, in priority order: size, CRC, address, function, length.
  // The CRC arrives on the line low byte first, so the older held byte is the low half.
  always_comb begin
    if (size_overflow || (byte_count < CW'(4))) begin
      chk_status = ST_SIZE_BAD;
    end else if ((hold_old != running_crc[7:0]) || (hold_new != running_crc[15:8])) begin
      chk_status = ST_CRC_BAD;
    end else if (hdr_addr != exp_addr) begin
      chk_status = ST_ADDR_BAD;
    end else if (hdr_func != {1'b0, exp_func}) begin
      // An exception response sets the top bit of the expected function code.
      chk_status = (hdr_func == {1'b1, exp_func}) ? ST_EXCEPT : ST_FUNC_BAD;
    end else if (pay_len != LW'(exp_dlen)) begin
      chk_status = ST_LEN_BAD;
    end else begin
      chk_status = ST_OK;
    end
  end

  // Result items: the status item in the check cycle, payload bytes in emit cycles.
  always_comb begin
    result_valid = 1'b0;
    result       = '0;
    case (state)
      S_CHECK: begin
        result_valid          = 1'b1;
        result.is_status      = 1'b1;
        result.status         = chk_status;
        result.exception_code = (chk_status == ST_EXCEPT) ? hdr_b2 : 8'd0;
        // Payload follows only for a good frame that carries data.
        result.last           = !((chk_status == ST_OK) && (pay_len != '0));
      end
      S_EMIT: begin
        result_valid        = 1'b1;
        result.payload_byte = rd_data;
        result.last         = (rd_addr == last_addr);
      end
      default: begin
        result_valid = 1'b0;
      end
    endcase
  end

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_addr <= ADDR_RESET;
      exp_func <= FUNC_RESET;
      exp_dlen <= DLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADDRESS:  exp_addr <= cfg_data;
        REG_FUNCTION: exp_func <= cfg_data[6:0];
        REG_DATA_LEN: exp_dlen <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Frame store: written on each accept that has room, read one payload byte at a time.
  always_ff @(posedge clk) begin
    if (accepted && has_room) begin
      frame_store[byte_count[AW-1:0]] <= request.rx_byte;
    end
    if (state == S_RD) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  // Payload-side registers need no reset.
  always_ff @(posedge clk) begin
    if (accepted && has_room) begin
      hold_new <= request.rx_byte;
      hold_old <= hold_new;
      if (byte_count == CW'(0)) hdr_addr <= request.rx_byte;
      if (byte_count == CW'(1)) hdr_func <= request.rx_byte;
      if (byte_count == CW'(2)) hdr_b2   <= request.rx_byte;
      // The byte two places back enters the CRC unit.
      crc_shift <= hold_old;
    end else if (state == S_CRC) begin
      crc_shift <= {1'b0, crc_shift[7:1]};
    end
    if (state == S_CHECK) begin
      rd_addr   <= AW'(2);
      last_addr <= AW'(byte_count - CW'(3));
    end else if (state == S_EMIT) begin
      rd_addr <= rd_addr + AW'(1);
    end
  end

  // Sequencer and frame control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_count    <= '0;
      running_crc   <= CRC_INIT;
      size_overflow <= 1'b0;
      end_seen      <= 1'b0;
      bit_cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accepted) begin
            end_seen <= request.frame_end;
            bit_cnt  <= '0;
            if (has_room) begin
              byte_count <= byte_count + CW'(1);
            end else begin
              size_overflow <= 1'b1;
            end
            if (has_room && (byte_count >= CW'(2))) begin
              state <= S_CRC;
            end else if (request.frame_end) begin
              state <= S_CHECK;
            end
          end
        end
        S_CRC: begin
          // One reflected CRC step per cycle, least significant bit first.
          running_crc <= {1'b0, running_crc[15:1]} ^ (crc_fb ? CRC_POLY : 16'h0000);
          bit_cnt     <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= end_seen ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          byte_count    <= '0;
          running_crc   <= CRC_INIT;
          size_overflow <= 1'b0;
          state <= ((chk_status == ST_OK) && (pay_len != '0)) ? S_RD : S_IDLE;
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          state <= (rd_addr == last_addr) ? S_IDLE : S_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A payload byte can only come out of the readout state.
  `MRC_ASSERT_IMPL(a_payload_in_emit, result_valid && !result.is_status, state == S_EMIT)
  // The CRC unit runs only after at least three bytes are stored.
  `MRC_ASSERT_IMPL(a_crc_needs_bytes, state == S_CRC, byte_count >= CW'(3))
  // A stored byte advances the count by exactly one.
  `MRC_ASSERT_NEXT(a_count_step, accepted && has_room,
                   byte_count == $past(byte_count) + CW'(1))
  // Every status item ends the frame state.
  `MRC_ASSERT_NEXT(a_status_clears, state == S_CHECK,
                   byte_count == '0 && running_crc == CRC_INIT && !size_overflow)

endmodule

>>> bench/modbus_rtu_response_checker_tb.sv
module modbus_rtu_response_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrc_pkg::*;

  localparam int FRAME_MAX = FRAME_MAX_DEF;
  // A mid-frame request keeps the block busy through its CRC steps without
  // producing a result, so this many cycles covers any work still in flight.
  localparam int SETTLE_CYCLES = 24;
  // The index field has room for a fourth register that does not exist.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    FK_GOOD,
    FK_CRC_BAD,
    FK_ADDR_BAD,
    FK_FUNC_BAD,
    FK_EXCEPTION,
    FK_LEN_BAD,
    FK_SHORT,
    FK_NOISE,
    FK_LONG
  } frame_kind_e;

  typedef logic [7:0] byte_q_t[$];

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  rx_req_t    request = '0;
  logic       result_valid;
  rsp_item_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Our own copy of the frame state, mirroring what the block holds.
  logic [7:0]  rx_store [FRAME_MAX];
  int unsigned rx_count = 0;
  logic [15:0] rx_crc = CRC_INIT;
  logic        rx_overflow = 1'b0;

  // Our own copy of the configuration registers.
  logic [7:0] want_address = ADDR_RESET;
  logic [6:0] want_function = FUNC_RESET;
  logic [5:0] want_data_len = DLEN_RESET;

  // Response items still owed by the block, oldest first.
  rsp_item_t   expected_items[$];
  int unsigned error_count = 0;
  // Chance, in percent, that the sender pauses after a request.
  int unsigned sender_idle_pct = 0;

  modbus_rtu_response_checker i_dut (
    .clk,
    .rst,
    .start,
    .busy,
    .request,
    .result_valid,
    .result,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  always #4 clk = ~clk;

  // One byte of the CRC-16/MODBUS update, least significant bit first.
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic rsp_item_t status_item(input logic [2:0] st, input logic [7:0] exc,
                                            input logic lst);
    rsp_item_t it;
    it = '0;
    it.is_status = 1'b1;
    it.status = st;
    it.exception_code = exc;
    it.last = lst;
    return it;
  endfunction

  // Applies one accepted request to the mirrored frame state and queues
  // the response items that it causes. Only the final byte of a frame
  // causes anything.
  function automatic void predict_response(input rx_req_t req);
    int unsigned n;
    int unsigned plen;
    rsp_item_t   it;
    if (rx_count < FRAME_MAX) begin
      // The CRC lags two bytes behind, so the trailing CRC bytes stay out of it.
      if (rx_count >= 2) begin
        rx_crc = crc16_fold(rx_crc, rx_store[rx_count - 2]);
      end
      rx_store[rx_count] = req.rx_byte;
      rx_count++;
    end else begin
      // Bytes beyond the store are dropped but spoil the frame.
      rx_overflow = 1'b1;
    end
    if (!req.frame_end) begin
      return;
    end
    n = rx_count;
    // The checks are ordered: size, CRC, address, function, length.
    if (rx_overflow || n < 4) begin
      expected_items.push_back(status_item(ST_SIZE_BAD, 8'h00, 1'b1));
    end else if (rx_store[n - 2] != rx_crc[7:0] || rx_store[n - 1] != rx_crc[15:8]) begin
      expected_items.push_back(status_item(ST_CRC_BAD, 8'h00, 1'b1));
    end else if (rx_store[0] != want_address) begin
      expected_items.push_back(status_item(ST_ADDR_BAD, 8'h00, 1'b1));
    end else if (rx_store[1] == {1'b1, want_function}) begin
      // An exception response carries its code in byte 2.
      expected_items.push_back(status_item(ST_EXCEPT, rx_store[2], 1'b1));
    end else if (rx_store[1] != {1'b0, want_function}) begin
      expected_items.push_back(status_item(ST_FUNC_BAD, 8'h00, 1'b1));
    end else if (n - 4 != want_data_len) begin
      expected_items.push_back(status_item(ST_LEN_BAD, 8'h00, 1'b1));
    end else begin
      plen = n - 4;
      expected_items.push_back(status_item(ST_OK, 8'h00, plen == 0));
      for (int i = 0; i < plen; i++) begin
        it = '0;
        it.payload_byte = rx_store[i + 2];
        it.last = (i + 1 == plen);
        expected_items.push_back(it);
      end
    end
    // The frame state starts over after every frame end.
    rx_count = 0;
    rx_crc = CRC_INIT;
    rx_overflow = 1'b0;
  endfunction

  // Builds one frame of the given kind against the current configuration.
  // Well-formed kinds get random payload and a correct CRC, then the
  // broken kinds damage exactly one part of it.
  function automatic byte_q_t build_frame(input frame_kind_e kind);
    byte_q_t     f;
    logic [15:0] crc;
    logic [7:0]  addr;
    logic [7:0]  fn;
    int unsigned plen;
    int unsigned idx;
    case (kind)
      FK_SHORT: begin
        repeat ($urandom_range(1, 3)) f.push_back(8'($urandom));
        return f;
      end
      FK_NOISE: begin
        repeat ($urandom_range(4, 8)) f.push_back(8'($urandom));
        return f;
      end
      FK_LONG: begin
        repeat ($urandom_range(FRAME_MAX + 1, FRAME_MAX + 6)) f.push_back(8'($urandom));
        return f;
      end
      default: ;
    endcase
    addr = want_address;
    fn = {1'b0, want_function};
    plen = want_data_len;
    case (kind)
      FK_ADDR_BAD: begin
        addr = addr ^ 8'($urandom_range(1, 255));
      end
      FK_FUNC_BAD: begin
        do begin
          fn = 8'($urandom);
        end while (fn == {1'b0, want_function} || fn == {1'b1, want_function});
      end
      FK_EXCEPTION: begin
        fn = {1'b1, want_function};
        plen = $urandom_range(0, 2);
      end
      FK_LEN_BAD: begin
        do begin
          plen = $urandom_range(0, want_data_len + 3);
        end while (plen == want_data_len || plen > FRAME_MAX - 4);
      end
      default: ;
    endcase
    f.push_back(addr);
    f.push_back(fn);
    repeat (plen) f.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (f[i]) begin
      crc = crc16_fold(crc, f[i]);
    end
    f.push_back(crc[7:0]);
    f.push_back(crc[15:8]);
    if (kind == FK_CRC_BAD) begin
      idx = f.size() - 1 - $urandom_range(0, 1);
      f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
    end
    return f;
  endfunction

  // Sends one byte request and waits until the block takes it. start is
  // left high when the next request follows at once; a pause lowers it.
  task automatic send_byte(input logic [7:0] data, input logic fin);
    int unsigned gap;
    start <= 1'b1;
    request <= rx_req_t'{rx_byte: data, frame_end: fin};
    do @(posedge clk); while (busy);
    predict_response(rx_req_t'{rx_byte: data, frame_end: fin});
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input byte_q_t f);
    foreach (f[i]) begin
      send_byte(f[i], i == f.size() - 1);
    end
  endtask

  // Stops sending, waits for every owed response item, then lets any
  // remaining mid-frame work finish so that the block is truly idle.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back, with random data in the bits
  // above each register's width. Optionally writes the unused index last,
  // which must leave the others alone.
  task automatic configure(input logic [7:0] addr, input logic [6:0] func,
                           input logic [5:0] dlen, input bit poke_unused);
    logic [1:0] idx_q[$];
    logic [7:0] data_q[$];
    idx_q.push_back(REG_ADDRESS);
    data_q.push_back(addr);
    idx_q.push_back(REG_FUNCTION);
    data_q.push_back({1'($urandom), func});
    idx_q.push_back(REG_DATA_LEN);
    data_q.push_back({2'($urandom), dlen});
    if (poke_unused) begin
      idx_q.push_back(REG_UNUSED);
      data_q.push_back(8'($urandom));
    end
    cfg_valid <= 1'b1;
    foreach (idx_q[i]) begin
      cfg_index <= idx_q[i];
      cfg_data <= data_q[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx_q[i])
        REG_ADDRESS:  want_address = data_q[i];
        REG_FUNCTION: want_function = data_q[i][6:0];
        REG_DATA_LEN: want_data_len = data_q[i][5:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Random frames until roughly the given number of byte requests has gone
  // out. Half are well-formed; the rest exercise each failure but the oversized frame.
  task automatic run_random_frames(input int unsigned budget);
    int unsigned sent;
    int unsigned r;
    frame_kind_e kind;
    byte_q_t     f;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 50) begin
        kind = FK_GOOD;
      end else if (r < 58) begin
        kind = FK_CRC_BAD;
      end else if (r < 64) begin
        kind = FK_ADDR_BAD;
      end else if (r < 70) begin
        kind = FK_FUNC_BAD;
      end else if (r < 78) begin
        kind = FK_EXCEPTION;
      end else if (r < 86) begin
        kind = FK_LEN_BAD;
      end else if (r < 93) begin
        kind = FK_SHORT;
      end else begin
        kind = FK_NOISE;
      end
      f = build_frame(kind);
      send_frame(f);
      sent += f.size();
    end
    wait_idle();
  endtask

  // With the registers at their reset values, one frame for each status
  // except the oversized one, back to back.
  task automatic test_each_status();
    sender_idle_pct = 0;
    for (int k = FK_GOOD; k <= FK_LEN_BAD; k++) begin
      send_frame(build_frame(frame_kind_e'(k)));
    end
    wait_idle();
  endtask

  // Frames of one and three bytes are too short, whatever they hold.
  task automatic test_short_frames();
    sender_idle_pct = 0;
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  // All registers at zero, sender never pauses.
  task automatic test_low_extremes();
    configure(8'h00, 7'h00, 6'd0, 1'b1);
    sender_idle_pct = 0;
    run_random_frames(30);
  endtask

  // Address and function at their maximum, sender pauses often.
  task automatic test_high_extremes();
    configure(8'hFF, 7'h7F, 6'($urandom_range(1, 6)), 1'b0);
    sender_idle_pct = 61;
    run_random_frames(40);
  endtask

  // Largest payload fills the store exactly; frames one or more bytes
  // longer overflow it. Results here cannot be held off, so the
  // receiver-stall phase amounts to a phase without pauses.
  task automatic test_full_frames();
    configure(8'($urandom), 7'($urandom), 6'd60, 1'b0);
    sender_idle_pct = 0;
    send_frame(build_frame(FK_GOOD));
    send_frame(build_frame(FK_LONG));
    send_frame(build_frame(FK_LEN_BAD));
    send_frame(build_frame(FK_LONG));
    wait_idle();
  endtask

  // Several random settings with short payloads and occasional pauses.
  task automatic test_random_configs();
    sender_idle_pct = 31;
    repeat (4) begin
      configure(8'($urandom), 7'($urandom), 6'($urandom_range(0, 8)), 1'b1);
      run_random_frames(10);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Every strobed result is taken at the edge that ends its cycle and
  // compared with the oldest owed item.
  always @(posedge clk) begin : result_monitor
    rsp_item_t want;
    if (!rst && result_valid) begin
      if (expected_items.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, result);
        error_count++;
      end else begin
        want = expected_items.pop_front();
        check_field("is_status", want.is_status, result.is_status);
        check_field("status", want.status, result.status);
        check_field("exception_code", want.exception_code, result.exception_code);
        check_field("payload_byte", want.payload_byte, result.payload_byte);
        check_field("last", want.last, result.last);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_each_status();
    test_short_frames();
    test_low_extremes();
    test_high_extremes();
    test_full_frames();
    test_random_configs();
    wait_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run, which stays well under a tenth of this.
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
